@@ rtl/sce_pkg.sv @@
`timescale 1ns / 1ps

package sce_pkg;

    localparam int NUM_SYMS        = 28;
    localparam int SYM_W           = 5;
    localparam int CODE_W          = 7;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 8;
    localparam int NUM_KEY_REGS    = 6;
    localparam int KEY_IDX_W       = 3;
    // key length, capped at the number of key registers
    localparam int KEY_LEN_RAW     = 6;
    localparam int KEY_LEN         = (KEY_LEN_RAW < 1) ? 1 :
                                     (KEY_LEN_RAW > NUM_KEY_REGS) ? NUM_KEY_REGS :
                                     KEY_LEN_RAW;
    localparam int FIRST_PAIR_CODE = 80;

    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_SYMBOL = 2'd1,
        ERR_KEY    = 2'd2
    } err_t;

    localparam sym_t KEY_RESET [NUM_KEY_REGS] = '{
        SYM_W'(18), SYM_W'(14), SYM_W'(12), SYM_W'(1), SYM_W'(17), SYM_W'(4)
    };

    typedef struct packed {
        logic has;
        digit_t code;
    } single_t;

    // one-digit codes of E,T,A,O,N,R,I,S
    function automatic single_t single_code(sym_t s);
        single_t r;
        r = '{has: 1'b1, code: '0};
        unique case (s)
            SYM_W'(4):  r.code = DIGIT_W'(0);
            SYM_W'(19): r.code = DIGIT_W'(1);
            SYM_W'(0):  r.code = DIGIT_W'(2);
            SYM_W'(14): r.code = DIGIT_W'(3);
            SYM_W'(13): r.code = DIGIT_W'(4);
            SYM_W'(17): r.code = DIGIT_W'(5);
            SYM_W'(8):  r.code = DIGIT_W'(6);
            SYM_W'(18): r.code = DIGIT_W'(7);
            default:    r.has  = 1'b0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic latch_char;
        logic build_start;
        logic scan_step;
        logic col_step;
        logic mark_ready;
        logic load_res;
        logic use_input;
        logic sel_second;
    } sce_cmd_t;

    typedef struct packed {
        logic table_ready;
        logic key_ok;
        logic scan_done;
        logic cols_done;
        logic res_two;
    } sce_status_t;

endpackage

@@ rtl/sce_char_if.sv @@
`timescale 1ns / 1ps

interface sce_char_if;
    logic                   valid;
    logic                   ready;
    logic [7:0]             in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

@@ rtl/sce_digit_if.sv @@
`timescale 1ns / 1ps

interface sce_digit_if;
    logic       valid;
    logic       ready;
    logic [3:0] out_digit;
    logic       last_digit;
    logic [1:0] error_code;

    modport source (output valid, output out_digit, output last_digit, output error_code,
                    input ready);
    modport sink (input valid, input out_digit, input last_digit, input error_code,
                  output ready);
endinterface

@@ rtl/sce_ctrl.sv @@
`timescale 1ns / 1ps

module sce_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sce_pkg::sce_status_t status,
    output sce_pkg::sce_cmd_t    cmd
);
    import sce_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COLS,
        S_LOAD,
        S_OUT1,
        S_OUT2
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire, out_fire;

    assign in_fire  = in_valid && in_ready_reg;
    assign out_fire = out_valid_reg && out_ready;
    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.sel_second = (state_reg == S_OUT2);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.latch_char = 1'b1;
                    in_ready_next  = 1'b0;
                    if (status.table_ready)
                    begin
                        cmd.load_res   = 1'b1;
                        cmd.use_input  = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_OUT1;
                    end
                    else
                    begin
                        cmd.build_start = 1'b1;
                        if (status.key_ok)
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            // bad key: no table to build
                            cmd.mark_ready = 1'b1;
                            state_next     = S_LOAD;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_COLS;
                end
            end
            S_COLS:
            begin
                cmd.col_step = 1'b1;
                if (status.cols_done)
                begin
                    cmd.mark_ready = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_res   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT1;
            end
            S_OUT1:
            begin
                if (out_fire)
                begin
                    if (status.res_two)
                    begin
                        state_next = S_OUT2;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        in_ready_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_OUT2:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    in_ready_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/sce_datapath.sv @@
`timescale 1ns / 1ps

module sce_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [4:0]           cfg_data,
    input  logic [7:0]           in_char,
    input  sce_pkg::sce_cmd_t    cmd,
    output sce_pkg::sce_status_t status,
    output logic [3:0]           out_digit,
    output logic                 last_digit,
    output logic [1:0]           error_code
);
    import sce_pkg::*;

    localparam int POS_SUM_W = SYM_W + 1;

    sym_t   key_reg [NUM_KEY_REGS];
    logic   table_ready_reg;
    logic   key_valid_reg;
    char_t  char_reg;

    // column-read matrix, positions below KEY_LEN come straight from the key
    sym_t   mat_reg [NUM_SYMS];
    code_t  code_table [NUM_SYMS];

    sym_t     scan_reg;
    sym_t     mat_n_reg;
    key_idx_t col_reg;
    sym_t     pos_reg;
    code_t    next_code_reg;

    digit_t res0_digit_reg;
    logic   res0_last_reg;
    err_t   res0_err_reg;
    digit_t res1_digit_reg;
    logic   res_two_reg;

    logic   key_ok;
    logic   scan_used;
    sym_t   col_sym;
    logic [POS_SUM_W-1:0] pos_sum;

    // key legality: in range and no repeats
    always_comb
    begin
        key_ok = 1'b1;
        for (int j = 0; j < KEY_LEN; j++)
        begin
            if (key_reg[j] >= SYM_W'(NUM_SYMS))
            begin
                key_ok = 1'b0;
            end
            for (int k = j + 1; k < KEY_LEN; k++)
            begin
                if (key_reg[j] == key_reg[k])
                begin
                    key_ok = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        scan_used = 1'b0;
        for (int j = 0; j < KEY_LEN; j++)
        begin
            if (key_reg[j] == scan_reg)
            begin
                scan_used = 1'b1;
            end
        end
    end

    assign col_sym = (pos_reg < SYM_W'(KEY_LEN)) ? key_reg[pos_reg[KEY_IDX_W-1:0]]
                                                  : mat_reg[pos_reg];
    assign pos_sum = POS_SUM_W'(pos_reg) + POS_SUM_W'(KEY_LEN);

    assign status.table_ready = table_ready_reg;
    assign status.key_ok      = key_ok;
    assign status.scan_done   = (scan_reg == SYM_W'(NUM_SYMS - 1));
    assign status.cols_done   = (col_reg == KEY_IDX_W'(KEY_LEN - 1)) &&
                                (pos_sum >= POS_SUM_W'(NUM_SYMS));
    assign status.res_two     = res_two_reg;

    // result lookup
    char_t   char_sel;
    logic    sym_ok;
    sym_t    sym;
    single_t sc;
    code_t   tcode;
    code_t   pair_off;
    logic    pair_hi;
    digit_t  r0_digit;
    logic    r0_last;
    err_t    r0_err;
    digit_t  r1_digit;
    logic    r_two;

    always_comb
    begin
        char_sel = cmd.use_input ? in_char : char_reg;
        sym_ok   = 1'b1;
        sym      = '0;
        if (char_sel >= "A" && char_sel <= "Z")
        begin
            sym = SYM_W'(char_sel - "A");
        end
        else if (char_sel == ".")
        begin
            sym = SYM_W'(26);
        end
        else if (char_sel == "/")
        begin
            sym = SYM_W'(27);
        end
        else
        begin
            sym_ok = 1'b0;
        end
        sc       = single_code(sym);
        tcode    = code_table[sym];
        pair_off = tcode - CODE_W'(FIRST_PAIR_CODE);
        pair_hi  = (pair_off >= CODE_W'(10));

        r0_digit = '0;
        r0_last  = 1'b1;
        r0_err   = ERR_OK;
        r1_digit = '0;
        r_two    = 1'b0;
        if (!key_valid_reg)
        begin
            r0_err = ERR_KEY;
        end
        else if (char_sel >= "0" && char_sel <= "9")
        begin
            r0_digit = DIGIT_W'(char_sel - "0");
            r1_digit = DIGIT_W'(char_sel - "0");
            r0_last  = 1'b0;
            r_two    = 1'b1;
        end
        else if (!sym_ok)
        begin
            r0_err = ERR_SYMBOL;
        end
        else if (sc.has)
        begin
            r0_digit = sc.code;
        end
        else
        begin
            // two-digit codes run 80..99
            r0_digit = pair_hi ? DIGIT_W'(9) : DIGIT_W'(8);
            r1_digit = pair_hi ? DIGIT_W'(pair_off - CODE_W'(10)) : DIGIT_W'(pair_off);
            r0_last  = 1'b0;
            r_two    = 1'b1;
        end
    end

    assign out_digit  = cmd.sel_second ? res1_digit_reg : res0_digit_reg;
    assign last_digit = cmd.sel_second ? 1'b1 : res0_last_reg;
    assign error_code = cmd.sel_second ? ERR_OK : res0_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_KEY_REGS; j++)
            begin
                key_reg[j] <= KEY_RESET[j];
            end
            table_ready_reg <= 1'b0;
            key_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index < KEY_IDX_W'(NUM_KEY_REGS)))
            begin
                key_reg[cfg_index] <= cfg_data;
                table_ready_reg    <= 1'b0;
            end
            if (cmd.mark_ready)
            begin
                table_ready_reg <= 1'b1;
                key_valid_reg   <= key_ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_char)
        begin
            char_reg <= in_char;
        end
        if (cmd.build_start)
        begin
            scan_reg      <= '0;
            mat_n_reg     <= SYM_W'(KEY_LEN);
            col_reg       <= '0;
            pos_reg       <= '0;
            next_code_reg <= CODE_W'(FIRST_PAIR_CODE);
        end
        if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + SYM_W'(1);
            if (!scan_used)
            begin
                mat_reg[mat_n_reg] <= scan_reg;
                mat_n_reg          <= mat_n_reg + SYM_W'(1);
            end
        end
        if (cmd.col_step)
        begin
            if (!single_code(col_sym).has)
            begin
                code_table[col_sym] <= next_code_reg;
                next_code_reg       <= next_code_reg + CODE_W'(1);
            end
            if (pos_sum < POS_SUM_W'(NUM_SYMS))
            begin
                pos_reg <= pos_sum[SYM_W-1:0];
            end
            else
            begin
                col_reg <= col_reg + KEY_IDX_W'(1);
                pos_reg <= SYM_W'(col_reg) + SYM_W'(1);
            end
        end
        if (cmd.load_res)
        begin
            res0_digit_reg <= r0_digit;
            res0_last_reg  <= r0_last;
            res0_err_reg   <= r0_err;
            res1_digit_reg <= r1_digit;
            res_two_reg    <= r_two;
        end
    end

endmodule

@@ rtl/straddling_checkerboard_encoder.sv @@
`timescale 1ns / 1ps

// straddling checkerboard encoder, ascii characters in, decimal digits out
// char_ch: one character per word; digit_ch: one digit per word, with a
// last flag on the final digit of a character and an error code
// key registers 0..5 are written through cfg_we / cfg_index / cfg_data;
// the user is to write them only while the block is idle, which the
// block itself does not enforce; a write to index 6 or 7 is dropped
// the first character after reset or after a key write triggers a table
// build: the alphabet is scanned into the matrix, then the matrix is read
// by columns into the code table (both skipped for a bad key)
// with the table built, the first digit is valid the cycle after accept;
// the controller hands the words of a character one at a time through
// the result register; a stalled receiver holds the current word; no new
// character is taken until the last word of the current one is accepted
// reset restores the key to its default and marks the table stale

module straddling_checkerboard_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    sce_char_if.sink    char_ch,
    sce_digit_if.source digit_ch
);
    import sce_pkg::*;

    sce_cmd_t    cmd;
    sce_status_t status;

    sce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (char_ch.valid),
        .in_ready  (char_ch.ready),
        .out_valid (digit_ch.valid),
        .out_ready (digit_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sce_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_char    (char_ch.in_char),
        .cmd        (cmd),
        .status     (status),
        .out_digit  (digit_ch.out_digit),
        .last_digit (digit_ch.last_digit),
        .error_code (digit_ch.error_code)
    );

endmodule
